// File: hw/rtl/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// shared codes, reset values and inter-module types of the cone target search
// ----------------------------------------------------------------------------
package ntc_pkg;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  // status codes of a result
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_COS_MELEE  = 2'd0;
  localparam logic [1:0] CFG_COS_RANGED = 2'd1;
  localparam logic [1:0] CFG_DEF_RANGE  = 2'd2;

  // configuration reset values
  localparam logic [14:0] COS_MELEE_RST  = 15'd10650;
  localparam logic [14:0] COS_RANGED_RST = 15'd15401;
  localparam logic [15:0] DEF_RANGE_RST  = 16'd1024;

  // forward vector saturation, q1.14
  localparam logic signed [15:0] DIR_MAX = 16'sd16384;
  localparam logic signed [15:0] DIR_MIN = -16'sd16384;

  // largest per-axis offset still considered, sixteenths
  localparam int FAR_LIM = 65535;

  // query setup handed to the datapath at the start of a scan
  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        range;
    logic [14:0]        cos;
  } query_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic found;
  } scan_t;

endpackage

// File: hw/rtl/nearest_target_in_cone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_in_cone
// table of target points with alive flags and a nearest-in-view-cone search
// ----------------------------------------------------------------------------
// Each request carries one operation and yields exactly one result. Append,
// set-alive and clear have their result registered in the cycle after
// acceptance, and a new request can be taken every cycle while the result
// register drains. A query walks the stored entries in order through the
// single read port of the table memory, one entry per cycle, into a
// six-stage test pipeline (offset, products, sums, squared cone compare,
// verdict, nearest update); its result is loaded once the scan has drained.
// No requests are accepted during a query scan.
// Positions are held in one memory word per entry (x in the low bits, then
// y, then z) and alive flags in a second memory; neither is cleared, since
// only entries below the count are ever read and every one was written by an
// append. The cone test avoids square roots: with to = target - eye, an alive
// entry qualifies when 0 < |to|^2 <= R^2, forward.to >= 0 and
// (forward.to)^2 >= cos^2 |to|^2; an entry more than 65535 sixteenths off
// the eye on any axis never qualifies. The earliest of equally near entries
// wins. Configuration writes must only be issued while no request is open.
// ----------------------------------------------------------------------------
module nearest_target_in_cone #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [5:0]                   entry_index_i,
  input  logic                         alive_flag_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [15:0]           dir_x_i,
  input  logic signed [15:0]           dir_y_i,
  input  logic signed [15:0]           dir_z_i,
  input  logic [15:0]                  reach_i,
  input  logic                         melee_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic                         hit_o,
  output logic [5:0]                   hit_index_o,
  output logic [6:0]                   entry_count_o
);

  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int IW  = (CW > 6) ? CW : 6;   // set index compare width
  localparam int HW  = (AW > 6) ? AW : 6;   // hit index output width
  localparam int EW  = (CW > 7) ? CW : 7;   // count output width
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  // configuration registers
  logic [14:0] cos_melee_q;
  logic [14:0] cos_ranged_q;
  logic [15:0] def_range_q;

  // sequencer and result registers
  state_e      state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic        hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;

  logic        accept;
  logic        out_free;
  ntc_pkg::op_e op;
  logic [IW-1:0] idx_ext;
  logic [IW-1:0] cnt_ext;
  logic [HW-1:0] hit_ext;
  logic [EW-1:0] cnt_out_ext;

  // table port
  logic        pos_we;
  logic        alive_we;
  logic [AW-1:0] wr_addr;
  logic        rd_en;
  logic        rd_valid;
  logic [AW-1:0] rd_idx;
  logic [3*COORD_BITS-1:0] rd_pos;
  logic        rd_alive;

  // datapath port
  logic        start;
  ntc_pkg::query_t qcfg;
  ntc_pkg::scan_t  pstat;
  logic [AW-1:0] best_idx;

  // result register can take a new value this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = ntc_pkg::op_e'(operation_i);

  assign idx_ext = IW'(entry_index_i);
  assign cnt_ext = IW'(count_q);

  // query setup: zero reach falls back to the default range
  assign qcfg.dir_x = dir_x_i;
  assign qcfg.dir_y = dir_y_i;
  assign qcfg.dir_z = dir_z_i;
  assign qcfg.range = (reach_i == 16'd0) ? def_range_q : reach_i;
  assign qcfg.cos   = melee_i ? cos_melee_q : cos_ranged_q;
  assign start      = accept && (op == ntc_pkg::OP_QUERY);

  // table writes happen only at request acceptance
  always_comb begin
    pos_we   = 1'b0;
    alive_we = 1'b0;
    wr_addr  = count_q[AW-1:0];
    if (accept) begin
      case (op)
        ntc_pkg::OP_APPEND: begin
          if (count_q < CNT_MAX) begin
            pos_we   = 1'b1;
            alive_we = 1'b1;
          end
        end
        ntc_pkg::OP_SET: begin
          wr_addr = idx_ext[AW-1:0];
          if (idx_ext < cnt_ext) begin
            alive_we = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    rd_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = ntc_pkg::STS_OK;
          hit_d       = 1'b0;
          hit_idx_d   = '0;
          case (op)
            ntc_pkg::OP_APPEND: begin
              if (count_q < CNT_MAX) begin
                count_d = count_q + CW'(1);
              end else begin
                status_d = ntc_pkg::STS_FULL;
              end
            end
            ntc_pkg::OP_SET: begin
              if (!(idx_ext < cnt_ext)) begin
                status_d = ntc_pkg::STS_RANGE;
              end
            end
            ntc_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            ntc_pkg::OP_QUERY: begin
              // result is loaded when the scan has drained
              out_valid_d = 1'b0;
              scan_d      = '0;
              state_d     = (count_q == '0) ? ST_DRAIN : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // one table read per cycle, entries in index order
        rd_en  = 1'b1;
        scan_d = scan_q + CW'(1);
        if (scan_d == count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !pstat.busy && out_free) begin
          out_valid_d = 1'b1;
          status_d    = ntc_pkg::STS_OK;
          hit_d       = pstat.found;
          hit_idx_d   = best_idx;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ntc_pkg::STS_OK;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
    end
  end

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_melee_q  <= ntc_pkg::COS_MELEE_RST;
      cos_ranged_q <= ntc_pkg::COS_RANGED_RST;
      def_range_q  <= ntc_pkg::DEF_RANGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ntc_pkg::CFG_COS_MELEE:  cos_melee_q  <= cfg_data_i[14:0];
        ntc_pkg::CFG_COS_RANGED: cos_ranged_q <= cfg_data_i[14:0];
        ntc_pkg::CFG_DEF_RANGE:  def_range_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ntc_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS),
    .AW          (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pos_we_i   (pos_we),
    .alive_we_i (alive_we),
    .wr_addr_i  (wr_addr),
    .wr_pos_i   ({point_z_i, point_y_i, point_x_i}),
    .wr_alive_i (alive_flag_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_q[AW-1:0]),
    .rd_valid_o (rd_valid),
    .rd_idx_o   (rd_idx),
    .rd_pos_o   (rd_pos),
    .rd_alive_o (rd_alive)
  );

  ntc_cone_pipe #(
    .COORD_BITS (COORD_BITS),
    .AW         (AW)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .qcfg_i      (qcfg),
    .eye_x_i     (point_x_i),
    .eye_y_i     (point_y_i),
    .eye_z_i     (point_z_i),
    .ent_valid_i (rd_valid),
    .ent_idx_i   (rd_idx),
    .ent_pos_i   (rd_pos),
    .ent_alive_i (rd_alive),
    .stat_o      (pstat),
    .best_idx_o  (best_idx)
  );

  // result port
  assign hit_ext       = HW'(hit_idx_q);
  assign cnt_out_ext   = EW'(count_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign hit_o         = hit_q;
  assign hit_index_o   = hit_ext[5:0];
  assign entry_count_o = cnt_out_ext[6:0];

endmodule

// File: hw/rtl/ntc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table
// target storage: position memory and alive memory, one write and one
// registered read per cycle
// ----------------------------------------------------------------------------
module ntc_table #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 24,
  parameter int AW          = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pos_we_i,
  input  logic                    alive_we_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [3*COORD_BITS-1:0] wr_pos_i,
  input  logic                    wr_alive_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr_i,
  output logic                    rd_valid_o,
  output logic [AW-1:0]           rd_idx_o,
  output logic [3*COORD_BITS-1:0] rd_pos_o,
  output logic                    rd_alive_o
);

  logic [3*COORD_BITS-1:0] pos_mem [MAX_ENTRIES];
  logic                    alive_mem [MAX_ENTRIES];

  logic                    rd_valid_q;
  logic [AW-1:0]           rd_idx_q;
  logic [3*COORD_BITS-1:0] rd_pos_q;
  logic                    rd_alive_q;

  always_ff @(posedge clk_i) begin
    if (pos_we_i) begin
      pos_mem[wr_addr_i] <= wr_pos_i;
    end
    if (alive_we_i) begin
      alive_mem[wr_addr_i] <= wr_alive_i;
    end
    if (rd_en_i) begin
      rd_pos_q   <= pos_mem[rd_addr_i];
      rd_alive_q <= alive_mem[rd_addr_i];
      rd_idx_q   <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en_i;
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_idx_o   = rd_idx_q;
  assign rd_pos_o   = rd_pos_q;
  assign rd_alive_o = rd_alive_q;

endmodule

// File: hw/rtl/ntc_cone_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_cone_pipe
// per-entry cone test pipeline and nearest-hit tracking
// ----------------------------------------------------------------------------
module ntc_cone_pipe #(
  parameter int COORD_BITS = 24,
  parameter int AW         = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  ntc_pkg::query_t              qcfg_i,
  input  logic signed [COORD_BITS-1:0] eye_x_i,
  input  logic signed [COORD_BITS-1:0] eye_y_i,
  input  logic signed [COORD_BITS-1:0] eye_z_i,
  input  logic                         ent_valid_i,
  input  logic [AW-1:0]                ent_idx_i,
  input  logic [3*COORD_BITS-1:0]      ent_pos_i,
  input  logic                         ent_alive_i,
  output ntc_pkg::scan_t               stat_o,
  output logic [AW-1:0]                best_idx_o
);

  localparam int CB = COORD_BITS;
  localparam int TW = (COORD_BITS + 1 > 18) ? COORD_BITS + 1 : 18;
  localparam logic signed [TW-1:0] FAR_POS = TW'(ntc_pkg::FAR_LIM);
  localparam logic signed [TW-1:0] FAR_NEG = -FAR_POS;

  // query setup
  logic signed [CB-1:0] eye_q [3];
  logic signed [15:0]   dir_q [3];
  logic [31:0]          r2_q;
  logic [29:0]          cc_q;

  // stage 1: offsets
  logic                 v1_q;
  logic [AW-1:0]        idx1_q;
  logic                 ok1_q;
  logic signed [16:0]   t1_q [3];
  // stage 2: products
  logic                 v2_q;
  logic [AW-1:0]        idx2_q;
  logic                 ok2_q;
  logic [31:0]          sq2_q [3];
  logic signed [30:0]   pr2_q [3];
  // stage 3: sums
  logic                 v3_q;
  logic [AW-1:0]        idx3_q;
  logic                 ok3_q;
  logic [33:0]          d2_3_q;
  logic signed [32:0]   dot3_q;
  // stage 4: squares against cone
  logic                 v4_q;
  logic [AW-1:0]        idx4_q;
  logic                 base4_q;
  logic [33:0]          d2_4_q;
  logic [63:0]          dotsq4_q;
  logic [46:0]          ccl4_q;
  logic [46:0]          cch4_q;
  // stage 5: verdict
  logic                 v5_q;
  logic [AW-1:0]        idx5_q;
  logic                 qual5_q;
  logic [33:0]          d2_5_q;
  // best so far
  logic                 found_q;
  logic [AW-1:0]        best_idx_q;
  logic [33:0]          best_d2_q;

  logic signed [15:0]   dir_in [3];
  logic signed [15:0]   dir_sat [3];
  logic signed [CB-1:0] eye_in [3];
  logic signed [CB-1:0] pos_k [3];
  logic signed [TW-1:0] t_full [3];
  logic [2:0]           far;
  logic signed [16:0]   t_d [3];
  logic signed [33:0]   sq_full [3];
  logic signed [32:0]   pr_full [3];
  logic [63:0]          ccd2;
  logic                 take;

  assign dir_in[0] = qcfg_i.dir_x;
  assign dir_in[1] = qcfg_i.dir_y;
  assign dir_in[2] = qcfg_i.dir_z;
  assign eye_in[0] = eye_x_i;
  assign eye_in[1] = eye_y_i;
  assign eye_in[2] = eye_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // saturate forward components
      if (dir_in[k] > ntc_pkg::DIR_MAX) begin
        dir_sat[k] = ntc_pkg::DIR_MAX;
      end else if (dir_in[k] < ntc_pkg::DIR_MIN) begin
        dir_sat[k] = ntc_pkg::DIR_MIN;
      end else begin
        dir_sat[k] = dir_in[k];
      end
      // offset from eye, flagged when out of the squared-math range
      pos_k[k]  = ent_pos_i[k*CB +: CB];
      t_full[k] = TW'(pos_k[k]) - TW'(eye_q[k]);
      far[k]    = (t_full[k] > FAR_POS) || (t_full[k] < FAR_NEG);
      t_d[k]    = t_full[k][16:0];
      sq_full[k] = t1_q[k] * t1_q[k];
      pr_full[k] = dir_q[k] * t1_q[k];
    end
  end

  assign ccd2 = {cch4_q, 17'b0} + 64'(ccl4_q);
  assign take = v5_q && qual5_q && (!found_q || (d2_5_q < best_d2_q));

  // payload stages
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int k = 0; k < 3; k++) begin
        eye_q[k] <= eye_in[k];
        dir_q[k] <= dir_sat[k];
      end
      r2_q <= 32'(qcfg_i.range) * 32'(qcfg_i.range);
      cc_q <= 30'(qcfg_i.cos) * 30'(qcfg_i.cos);
    end
    idx1_q <= ent_idx_i;
    ok1_q  <= ent_alive_i && !(|far);
    for (int k = 0; k < 3; k++) begin
      t1_q[k]  <= t_d[k];
      sq2_q[k] <= sq_full[k][31:0];
      pr2_q[k] <= pr_full[k][30:0];
    end
    idx2_q <= idx1_q;
    ok2_q  <= ok1_q;
    idx3_q <= idx2_q;
    ok3_q  <= ok2_q;
    d2_3_q <= 34'(sq2_q[0]) + 34'(sq2_q[1]) + 34'(sq2_q[2]);
    dot3_q <= 33'(pr2_q[0]) + 33'(pr2_q[1]) + 33'(pr2_q[2]);
    idx4_q   <= idx3_q;
    base4_q  <= ok3_q && (d2_3_q != 34'd0) && (d2_3_q <= 34'(r2_q)) && !dot3_q[32];
    d2_4_q   <= d2_3_q;
    dotsq4_q <= 64'(dot3_q[31:0]) * 64'(dot3_q[31:0]);
    ccl4_q   <= 47'(cc_q) * 47'(d2_3_q[16:0]);
    cch4_q   <= 47'(cc_q) * 47'(d2_3_q[33:17]);
    idx5_q  <= idx4_q;
    qual5_q <= base4_q && !(dotsq4_q < ccd2);
    d2_5_q  <= d2_4_q;
  end

  // stage valids and best tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_d2_q  <= '0;
    end else begin
      v1_q <= ent_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (start_i) begin
        found_q    <= 1'b0;
        best_idx_q <= '0;
        best_d2_q  <= '0;
      end else if (take) begin
        found_q    <= 1'b1;
        best_idx_q <= idx5_q;
        best_d2_q  <= d2_5_q;
      end
    end
  end

  assign stat_o.busy  = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign stat_o.found = found_q;
  assign best_idx_o   = best_idx_q;

endmodule

// File: bench/tb_nearest_target_in_cone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_target_in_cone
// self-checking bench for the cone target search: target table upkeep and
// nearest-in-cone queries are predicted in a scoreboard and compared against
// every result, under random request gaps, result back-pressure and several
// register settings
// ----------------------------------------------------------------------------
module tb_nearest_target_in_cone;

  localparam int NUM_ENTRIES     = 64;
  localparam int RANDOM_REQUESTS = 900;
  localparam int PHASE_REQUESTS  = 150;
  // covers a full-table query plus result back-pressure and gaps
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 80;

  typedef longint unsigned u64_t;

  // one request as seen on the request channel
  typedef struct {
    ntc_pkg::op_e       op;
    logic [5:0]         index;
    logic               alive;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [15:0]        reach;
    logic               melee;
  } request_t;

  // one result as seen on the result channel
  typedef struct {
    ntc_pkg::status_e status;
    logic             hit;
    logic [5:0]       hit_index;
    logic [6:0]       entries;
  } verdict_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the target table and registers, predicts the
  // verdict of each accepted request and checks results in order
  // --------------------------------------------------------------------------
  class cone_scoreboard;
    logic signed [23:0] pos_x [NUM_ENTRIES];
    logic signed [23:0] pos_y [NUM_ENTRIES];
    logic signed [23:0] pos_z [NUM_ENTRIES];
    bit                 alive [NUM_ENTRIES];
    int unsigned        fill;
    logic [14:0]        cos_melee;
    logic [14:0]        cos_ranged;
    logic [15:0]        def_range;
    verdict_t           expected_q[$];
    int                 mismatches;
    int                 results;
    int                 queries;
    int                 hits;
    int                 rejects;

    function new();
      foreach (alive[i]) begin
        alive[i] = 1'b0;
        pos_x[i] = '0;
        pos_y[i] = '0;
        pos_z[i] = '0;
      end
      fill       = 0;
      cos_melee  = ntc_pkg::COS_MELEE_RST;
      cos_ranged = ntc_pkg::COS_RANGED_RST;
      def_range  = ntc_pkg::DEF_RANGE_RST;
      mismatches = 0;
      results    = 0;
      queries    = 0;
      hits       = 0;
      rejects    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        ntc_pkg::CFG_COS_MELEE:  cos_melee = data[14:0];
        ntc_pkg::CFG_COS_RANGED: cos_ranged = data[14:0];
        ntc_pkg::CFG_DEF_RANGE:  def_range = data;
        default: ;
      endcase
    endfunction

    function void note_request(request_t r);
      verdict_t v;
      longint   eye [3];
      longint   fwd [3];
      longint   t [3];
      longint   dot;
      u64_t     d2;
      u64_t     r2;
      u64_t     c2;
      u64_t     best;
      bit       far;
      v.status    = ntc_pkg::STS_OK;
      v.hit       = 1'b0;
      v.hit_index = '0;
      best        = 0;
      eye[0] = r.px;
      eye[1] = r.py;
      eye[2] = r.pz;
      fwd[0] = r.dx;
      fwd[1] = r.dy;
      fwd[2] = r.dz;
      for (int k = 0; k < 3; k++) begin
        if (fwd[k] > ntc_pkg::DIR_MAX) fwd[k] = ntc_pkg::DIR_MAX;
        if (fwd[k] < ntc_pkg::DIR_MIN) fwd[k] = ntc_pkg::DIR_MIN;
      end
      case (r.op)
        ntc_pkg::OP_APPEND: begin
          if (fill >= NUM_ENTRIES) begin
            v.status = ntc_pkg::STS_FULL;
          end else begin
            pos_x[fill] = r.px;
            pos_y[fill] = r.py;
            pos_z[fill] = r.pz;
            alive[fill] = r.alive;
            fill++;
          end
        end
        ntc_pkg::OP_SET: begin
          if (r.index >= fill) v.status = ntc_pkg::STS_RANGE;
          else alive[r.index] = r.alive;
        end
        ntc_pkg::OP_CLEAR: begin
          fill = 0;
          foreach (alive[i]) alive[i] = 1'b0;
        end
        default: begin
          queries++;
          r2 = (r.reach == 16'd0) ? u64_t'(def_range) : u64_t'(r.reach);
          r2 = r2 * r2;
          c2 = r.melee ? u64_t'(cos_melee) : u64_t'(cos_ranged);
          c2 = c2 * c2;
          for (int i = 0; i < fill; i++) begin
            if (!alive[i]) continue;
            t[0] = pos_x[i] - eye[0];
            t[1] = pos_y[i] - eye[1];
            t[2] = pos_z[i] - eye[2];
            far = 1'b0;
            d2  = 0;
            dot = 0;
            for (int k = 0; k < 3; k++) begin
              if (t[k] > ntc_pkg::FAR_LIM || t[k] < -ntc_pkg::FAR_LIM) far = 1'b1;
            end
            if (far) continue;
            for (int k = 0; k < 3; k++) begin
              d2  += u64_t'(t[k] * t[k]);
              dot += fwd[k] * t[k];
            end
            if (d2 == 0 || d2 > r2) continue;
            if (dot < 0) continue;
            if (u64_t'(dot) * u64_t'(dot) < c2 * d2) continue;
            // strict compare keeps the lowest index on equal distance
            if (!v.hit || d2 < best) begin
              v.hit       = 1'b1;
              best        = d2;
              v.hit_index = i[5:0];
            end
          end
        end
      endcase
      v.entries = fill[6:0];
      if (v.hit) hits++;
      if (v.status != ntc_pkg::STS_OK) rejects++;
      expected_q.push_back(v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request open: status %0d hit %0b index %0d",
                   results, got.status, got.hit, got.hit_index);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.hit !== want.hit ||
          got.hit_index !== want.hit_index || got.entries !== want.entries) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected status %0d hit %0b index %0d count %0d, %s %0d %0b %0d %0d",
                   results, want.status, want.hit, want.hit_index, want.entries,
                   "got", got.status, got.hit, got.hit_index, got.entries);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic        hit_o;
  logic [5:0]  hit_index_o;
  logic [6:0]  entry_count_o;

  // the request payload follows cur_req, which only changes at a rising edge
  request_t cur_req;

  logic [1:0]         operation_i;
  logic [5:0]         entry_index_i;
  logic               alive_flag_i;
  logic signed [23:0] point_x_i;
  logic signed [23:0] point_y_i;
  logic signed [23:0] point_z_i;
  logic signed [15:0] dir_x_i;
  logic signed [15:0] dir_y_i;
  logic signed [15:0] dir_z_i;
  logic [15:0]        reach_i;
  logic               melee_i;

  assign operation_i   = cur_req.op;
  assign entry_index_i = cur_req.index;
  assign alive_flag_i  = cur_req.alive;
  assign point_x_i     = cur_req.px;
  assign point_y_i     = cur_req.py;
  assign point_z_i     = cur_req.pz;
  assign dir_x_i       = cur_req.dx;
  assign dir_y_i       = cur_req.dy;
  assign dir_z_i       = cur_req.dz;
  assign reach_i       = cur_req.reach;
  assign melee_i       = cur_req.melee;

  nearest_target_in_cone #(
    .MAX_ENTRIES(NUM_ENTRIES),
    .COORD_BITS (24)
  ) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  cone_scoreboard sb;
  int             sent;
  int             burst_left;
  int             idle_cycles;
  int             stall_mode;
  int             stall_left;
  int             stall_tick;

  // --------------------------------------------------------------------------
  // monitor: both handshakes are decided by the values settled at the falling
  // edge, since stall, valid and payload only move right after a rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : monitor
    verdict_t got;
    bit       fired;
    if (rst_ni) begin
      fired = 1'b0;
      // results first: a request noted now cannot have its result out yet
      if (out_valid_o && !out_stall_i) begin
        got.status    = ntc_pkg::status_e'(status_o);
        got.hit       = hit_o;
        got.hit_index = hit_index_o;
        got.entries   = entry_count_o;
        sb.check_result(got);
        fired = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(cur_req);
        fired = 1'b1;
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results still open",
                 IDLE_LIMIT, sb.pending());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result back-pressure: free flow, light and heavy random stalls and a
  // periodic pattern, each mode kept for a randomly drawn number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= ((stall_tick % 8) < 5);
    endcase
  end

  // --------------------------------------------------------------------------
  // request builders; fields an operation ignores still carry random bits
  // --------------------------------------------------------------------------
  function automatic request_t any_request(ntc_pkg::op_e op);
    request_t r;
    r.op    = op;
    r.index = 6'($urandom);
    r.alive = 1'($urandom);
    r.px    = 24'($urandom);
    r.py    = 24'($urandom);
    r.pz    = 24'($urandom);
    r.dx    = 16'($urandom);
    r.dy    = 16'($urandom);
    r.dz    = 16'($urandom);
    r.reach = 16'($urandom);
    r.melee = 1'($urandom);
    return r;
  endfunction

  function automatic request_t append_at(logic signed [23:0] x, logic signed [23:0] y,
                                         logic signed [23:0] z, logic alive);
    request_t r;
    r       = any_request(ntc_pkg::OP_APPEND);
    r.px    = x;
    r.py    = y;
    r.pz    = z;
    r.alive = alive;
    return r;
  endfunction

  function automatic request_t set_alive(logic [5:0] idx, logic alive);
    request_t r;
    r       = any_request(ntc_pkg::OP_SET);
    r.index = idx;
    r.alive = alive;
    return r;
  endfunction

  function automatic request_t query_from(logic signed [23:0] x, logic signed [23:0] y,
                                          logic signed [23:0] z, logic signed [15:0] fx,
                                          logic signed [15:0] fy, logic signed [15:0] fz,
                                          logic [15:0] reach, logic melee);
    request_t r;
    r       = any_request(ntc_pkg::OP_QUERY);
    r.px    = x;
    r.py    = y;
    r.pz    = z;
    r.dx    = fx;
    r.dy    = fy;
    r.dz    = fz;
    r.reach = reach;
    r.melee = melee;
    return r;
  endfunction

  function automatic logic signed [23:0] near_point(logic signed [23:0] c, int spread);
    return c + 24'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // --------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps;
  // called at a rising edge, returns at the edge that took the request
  // --------------------------------------------------------------------------
  task automatic send(request_t r);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    cur_req    <= r;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    burst_left--;
    sent++;
  endtask

  // --------------------------------------------------------------------------
  // register setting: waits until every result is out, then writes all three
  // --------------------------------------------------------------------------
  task automatic apply_setting(int k);
    logic [15:0] cm;
    logic [15:0] cr;
    logic [15:0] dr;
    case (k % 6)
      1: begin
        cm = 16'd0;
        cr = 16'd16384;
        dr = 16'hFFFF;
      end
      2: begin
        cm = 16'd16384;
        cr = 16'd0;
        dr = 16'd1;
      end
      3: begin
        // cosine above one, with the unused top data bit set, and no
        // default range at all
        cm = 16'hFFFF;
        cr = 16'h7FFF;
        dr = 16'd0;
      end
      4: begin
        cm = {1'($urandom), 15'($urandom_range(0, 32767))};
        cr = {1'($urandom), 15'($urandom_range(8000, 16384))};
        dr = 16'($urandom_range(1, 65535));
      end
      5: begin
        cm = 16'd7000;
        cr = 16'd12000;
        dr = 16'd300;
      end
      default: begin
        cm = 16'(ntc_pkg::COS_MELEE_RST);
        cr = 16'(ntc_pkg::COS_RANGED_RST);
        dr = ntc_pkg::DEF_RANGE_RST;
      end
    endcase
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ntc_pkg::CFG_COS_MELEE;
    cfg_data_i  <= cm;
    sb.write_reg(ntc_pkg::CFG_COS_MELEE, cm);
    @(posedge clk_i);
    cfg_index_i <= ntc_pkg::CFG_COS_RANGED;
    cfg_data_i  <= cr;
    sb.write_reg(ntc_pkg::CFG_COS_RANGED, cr);
    @(posedge clk_i);
    cfg_index_i <= ntc_pkg::CFG_DEF_RANGE;
    cfg_data_i  <= dr;
    sb.write_reg(ntc_pkg::CFG_DEF_RANGE, dr);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    burst_left = 0;
  endtask

  // --------------------------------------------------------------------------
  // one scene: optionally clear, fill the table around a center point, poke
  // some alive flags, then run queries mostly aimed at stored targets
  // --------------------------------------------------------------------------
  task automatic run_scene(bit fill_up);
    request_t           r;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    int                 spread;
    int                 n;
    int                 j;
    int                 rl;
    longint             tx;
    longint             ty;
    longint             tz;
    real                len;
    case ($urandom_range(0, 4))
      0:       spread = 64;
      1:       spread = 1024;
      2:       spread = 8192;
      3:       spread = 65535;
      default: spread = 100000;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cx = 24'($urandom);
      cy = 24'($urandom);
      cz = 24'($urandom);
    end else begin
      cx = 24'(int'($urandom_range(0, 200000)) - 100000);
      cy = 24'(int'($urandom_range(0, 200000)) - 100000);
      cz = 24'(int'($urandom_range(0, 200000)) - 100000);
    end
    if (fill_up || $urandom_range(0, 2) == 0) send(any_request(ntc_pkg::OP_CLEAR));

    // now and then run past a full table
    if (fill_up) n = NUM_ENTRIES + 2;
    else if ($urandom_range(0, 11) == 0) n = $urandom_range(56, 68);
    else n = $urandom_range(1, 16);
    repeat (n) begin
      r       = any_request(ntc_pkg::OP_APPEND);
      r.alive = ($urandom_range(0, 9) < 8);
      if (sb.fill > 0 && $urandom_range(0, 7) == 0) begin
        // same spot as the last entry, so queries see equal distances
        r.px = sb.pos_x[sb.fill - 1];
        r.py = sb.pos_y[sb.fill - 1];
        r.pz = sb.pos_z[sb.fill - 1];
      end else if ($urandom_range(0, 11) == 0) begin
        r.px = cx;
        r.py = cy;
        r.pz = cz;
      end else begin
        r.px = near_point(cx, spread);
        r.py = near_point(cy, spread);
        r.pz = near_point(cz, spread);
      end
      send(r);
    end

    // flag updates, a few of them past the count
    repeat ($urandom_range(0, 4)) begin
      r       = any_request(ntc_pkg::OP_SET);
      r.index = 6'($urandom_range(0, (sb.fill + 2 > 63) ? 63 : sb.fill + 2));
      send(r);
    end

    repeat ($urandom_range(2, 8)) begin
      r = any_request(ntc_pkg::OP_QUERY);
      if ($urandom_range(0, 4) == 0) begin
        r.px = cx;
        r.py = cy;
        r.pz = cz;
      end else begin
        r.px = near_point(cx, spread / 8);
        r.py = near_point(cy, spread / 8);
        r.pz = near_point(cz, spread / 8);
      end
      if (sb.fill > 0 && $urandom_range(0, 4) != 0) begin
        // look roughly toward one stored target, jittered around the cone edge
        j   = $urandom_range(0, sb.fill - 1);
        tx  = sb.pos_x[j] - r.px;
        ty  = sb.pos_y[j] - r.py;
        tz  = sb.pos_z[j] - r.pz;
        len = $sqrt(real'(tx * tx + ty * ty + tz * tz));
        if (len > 0.5) begin
          r.dx = 16'($rtoi(16384.0 * tx / len) + int'($urandom_range(0, 600)) - 300);
          r.dy = 16'($rtoi(16384.0 * ty / len) + int'($urandom_range(0, 600)) - 300);
          r.dz = 16'($rtoi(16384.0 * tz / len) + int'($urandom_range(0, 600)) - 300);
        end
        case ($urandom_range(0, 3))
          0: r.reach = 16'd0;
          1: begin
            // range right around the target distance
            rl = $rtoi(len) + int'($urandom_range(0, 4)) - 2;
            if (rl < 0) r.reach = 16'd0;
            else if (rl > 65535) r.reach = 16'hFFFF;
            else r.reach = 16'(rl);
          end
          2: r.reach = 16'($urandom_range(1, (2 * spread > 65535) ? 65535 : 2 * spread));
          default: ;
        endcase
      end
      send(r);
    end

    // unstructured noise
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send(any_request(ntc_pkg::op_e'($urandom_range(0, 3))));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int phase;
    int next_switch;
    int last_request;
    sb          = new();
    sent        = 0;
    burst_left  = 0;
    cur_req     = any_request(ntc_pkg::OP_CLEAR);
    in_valid_i  = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = ntc_pkg::CFG_COS_MELEE;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values; eye mostly at the origin looking along +x
    send(query_from(0, 0, 0, 16384, 0, 0, 0, 0));         // empty table
    send(set_alive(0, 1));                                // flag past the count
    send(append_at(0, 0, 0, 1));                          // sits on the eye
    send(append_at(320, 0, 0, 1));
    send(append_at(320, 0, 0, 1));                        // equal distance, later
    send(append_at(160, 0, 0, 0));                        // nearer but not alive
    send(append_at(-160, 0, 0, 1));                       // behind the eye
    send(append_at(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1)); // coordinate corners
    send(query_from(0, 0, 0, 16384, 0, 0, 0, 0));         // default range, tie
    send(query_from(0, 0, 0, 16384, 0, 0, 0, 1));         // melee cone
    send(set_alive(3, 1));
    send(query_from(0, 0, 0, 16384, 0, 0, 0, 0));         // revived entry wins
    send(query_from(0, 0, 0, 16384, 0, 0, 100, 0));       // out of range
    send(query_from(0, 0, 0, 16'sh7FFF, 16'sh8000, 0, 16'hFFFF, 0)); // saturating forward
    send(query_from(0, 0, 0, -16384, 0, 0, 16'hFFFF, 1)); // turned around
    send(query_from(24'h7FFFEF, 24'h800000, 24'h7FFFFF, 16384, 0, 0, 0, 0));
    send(query_from(24'h800000, 24'h7FFFFF, 24'h800000, 0, 16384, 0, 0, 0));
    send(set_alive(6, 1));                                // index equal to count
    send(set_alive(63, 0));
    send(any_request(ntc_pkg::OP_CLEAR));
    send(query_from(0, 0, 0, 16384, 0, 0, 0, 0));         // cleared table
    send(set_alive(0, 1));

    // random part, register setting changed every so many requests
    phase        = 0;
    last_request = sent + RANDOM_REQUESTS;
    next_switch  = sent + PHASE_REQUESTS;
    run_scene(1'b1);
    while (sent < last_request) begin
      if (sent >= next_switch) begin
        phase++;
        apply_setting(phase);
        next_switch = sent + PHASE_REQUESTS;
      end
      run_scene(1'b0);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    // give a stray extra result the chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests over %0d register settings, %0d queries with %0d hits",
             sent, phase + 1, sb.queries, sb.hits);
    $display("%0d appends or flag updates rejected, %0d of %0d results mismatched",
             sb.rejects, sb.mismatches, sb.results);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_table.sv
hw/rtl/ntc_cone_pipe.sv
hw/rtl/nearest_target_in_cone.sv
bench/tb_nearest_target_in_cone.sv
